>>> rtl/ism_pkg.sv
// Shared types, constants and codes of the interval sieve marker.
package ism_pkg;

    localparam int SEG_SIZE  = 4096;
    localparam int SEG_AW    = $clog2(SEG_SIZE);
    localparam int CNT_W     = SEG_AW + 1;
    localparam int CFG_W     = 48;
    localparam int PRIME_W   = 24;
    localparam int NUM_W     = CFG_W + 1;
    localparam int OFF_W     = PRIME_W + 1;
    localparam int DIV_STEPS = CFG_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_LOWER = 1'b0;
    localparam logic CFG_UPPER = 1'b1;

    localparam logic [CFG_W-1:0] UPPER_RESET = CFG_W'(SEG_SIZE - 1);

    typedef struct packed {
        logic               start;
        logic [CFG_W-1:0]   dividend;
        logic [PRIME_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic               done;
        logic [PRIME_W-1:0] remainder;
    } t_rem_sts;

endpackage

>>> rtl/interval_sieve_marker.sv
// Top level of the interval sieve marker: sequencer, mark store and result register.
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid / o_in_stall  i_kind, i_prime, i_entry_index
//  output    out        o_out_valid / i_out_stall o_number, o_still_prime, o_marks_done
//  config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// After reset the 4096-entry mark store is swept to zero, one entry per cycle; no beat
// is taken meanwhile, but config writes are.
// From acceptance to the raising of o_out_valid: a query makes a registered store read,
// a clear sweeps the store, a mark runs the 48 steps of the remainder unit and then
// writes its marks (up to 4096 for the prime one); a zero prime or the unused kind 3
// goes straight to the result. The next beat can be taken in the cycle after the result
// is loaded; a result waits in the output register, so output stalls hold back the
// block only when a second result is ready before the first is taken.
module interval_sieve_marker
    import ism_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [PRIME_W-1:0] i_prime,
    input  logic [SEG_AW-1:0]  i_entry_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [NUM_W-1:0]   o_number,
    output logic               o_still_prime,
    output logic [CNT_W-1:0]   o_marks_done
);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CLR  = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_MARK = 3'd4;
    localparam logic [2:0] ST_QRD  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [SEG_AW-1:0]  r_addr, n_addr;
    logic [CFG_W-1:0]   r_lower, r_upper;
    logic               r_out_valid, n_out_valid;

    logic [OFF_W-1:0]   r_off, n_off;
    logic [PRIME_W-1:0] r_prime, n_prime;
    logic [CNT_W-1:0]   r_pop, n_pop;
    logic [CNT_W-1:0]   r_marks, n_marks;
    logic               r_inrange, n_inrange;
    logic [NUM_W-1:0]   r_qnum, n_qnum;
    logic [NUM_W-1:0]   r_res_number, n_res_number;
    logic               r_res_prime, n_res_prime;
    logic [CNT_W-1:0]   r_res_marks, n_res_marks;
    logic [NUM_W-1:0]   r_out_number;
    logic               r_out_prime;
    logic [CNT_W-1:0]   r_out_marks;

    logic               w_in_acc;
    logic               w_out_free;
    logic [NUM_W-1:0]   w_diff;
    logic [CNT_W-1:0]   w_pop;
    logic               w_mark_ok;

    logic               w_ram_we;
    logic [SEG_AW-1:0]  w_ram_waddr;
    logic [0:0]         w_ram_wdata;
    logic [0:0]         w_ram_rdata;

    t_rem_req           w_rem_req;
    t_rem_sts           w_rem_sts;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Segment population: upper minus lower, clamped when the unsigned
    // difference (which wraps when upper lies below lower) passes the segment size.
    assign w_diff = {1'b0, r_upper} - {1'b0, r_lower};
    assign w_pop  = (!w_diff[NUM_W-1] && (w_diff[CFG_W-1:0] <= CFG_W'(SEG_SIZE)))
                  ? w_diff[CNT_W-1:0] : CNT_W'(SEG_SIZE - 1);

    // The population never exceeds the segment size, so an offset below it
    // is always a legal store address.
    assign w_mark_ok = (r_off < {{(OFF_W-CNT_W){1'b0}}, r_pop});

    assign w_rem_req.start    = w_in_acc && (i_kind == KIND_MARK) && (i_prime != '0);
    assign w_rem_req.dividend = r_lower;
    assign w_rem_req.divisor  = i_prime;

    ism_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_sts   (w_rem_sts)
    );

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = 1'b0;
        case (r_state)
            ST_INIT, ST_CLR: begin
                w_ram_we = 1'b1;
            end
            ST_MARK: begin
                w_ram_we    = w_mark_ok;
                w_ram_waddr = r_off[SEG_AW-1:0];
                w_ram_wdata = 1'b1;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // The read is issued from the input field, so the accepting edge loads it.
    ism_ram #(
        .WIDTH (1),
        .DEPTH (SEG_SIZE)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (i_entry_index),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_off        = r_off;
        n_prime      = r_prime;
        n_pop        = r_pop;
        n_marks      = r_marks;
        n_inrange    = r_inrange;
        n_qnum       = r_qnum;
        n_res_number = r_res_number;
        n_res_prime  = r_res_prime;
        n_res_marks  = r_res_marks;
        n_out_valid  = i_out_stall ? r_out_valid : 1'b0;

        case (r_state)
            ST_INIT: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == SEG_AW'(SEG_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_res_number = '0;
                    n_res_prime  = 1'b0;
                    n_res_marks  = '0;
                    n_prime      = i_prime;
                    n_pop        = w_pop;
                    n_marks      = '0;
                    n_addr       = '0;
                    n_qnum       = {1'b0, r_lower} + {{(NUM_W-SEG_AW){1'b0}}, i_entry_index};
                    n_inrange    = ({1'b0, i_entry_index} < w_pop);
                    case (i_kind)
                        KIND_CLEAR: n_state = ST_CLR;
                        KIND_MARK:  n_state = (i_prime != '0) ? ST_MOD : ST_DONE;
                        KIND_QUERY: n_state = ST_QRD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == SEG_AW'(SEG_SIZE - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_MOD: begin
                if (w_rem_sts.done) begin
                    // First multiple at or above the lower bound, as an offset.
                    n_off   = (w_rem_sts.remainder == '0) ? '0
                            : ({1'b0, r_prime} - {1'b0, w_rem_sts.remainder});
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                if (w_mark_ok) begin
                    n_off   = r_off + {1'b0, r_prime};
                    n_marks = r_marks + 1'b1;
                end else begin
                    n_res_marks = r_marks;
                    n_state     = ST_DONE;
                end
            end
            ST_QRD: begin
                n_res_number = r_qnum;
                n_res_prime  = r_inrange && !w_ram_rdata[0] && (r_qnum != '0);
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_lower     <= '0;
            r_upper     <= UPPER_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOWER) begin
                    r_lower <= i_cfg_data;
                end else begin
                    r_upper <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off        <= n_off;
        r_prime      <= n_prime;
        r_pop        <= n_pop;
        r_marks      <= n_marks;
        r_inrange    <= n_inrange;
        r_qnum       <= n_qnum;
        r_res_number <= n_res_number;
        r_res_prime  <= n_res_prime;
        r_res_marks  <= n_res_marks;
        if (r_state == ST_DONE && w_out_free) begin
            r_out_number <= r_res_number;
            r_out_prime  <= r_res_prime;
            r_out_marks  <= r_res_marks;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_number      = r_out_number;
    assign o_still_prime = r_out_prime;
    assign o_marks_done  = r_out_marks;

    // The mark count can never pass the segment population.
    a_marks_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK) |-> (r_marks <= r_pop))
        else $error("mark count exceeds segment population");

    // A finished result is held while the output register is still occupied.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_valid && i_out_stall) |=> (r_state == ST_DONE))
        else $error("result left the sequencer while the output was blocked");

    // The remainder unit only finishes while the sequencer waits for it.
    a_rem_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_sts.done |-> (r_state == ST_MOD))
        else $error("remainder finished outside the modulo step");

endmodule

>>> rtl/ism_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ism_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ism_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
module ism_rem
    import ism_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_sts o_sts
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DIV_CW-1:0]   r_cnt, n_cnt;
    logic [CFG_W-1:0]    r_dvd, n_dvd;
    logic [PRIME_W-1:0]  r_dvs, n_dvs;
    logic [PRIME_W-1:0]  r_rem, n_rem;
    logic [PRIME_W:0]    w_trial;
    logic [PRIME_W:0]    w_diff;

    assign w_trial = {r_rem, r_dvd[CFG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // Subtract when the partial remainder reaches the divisor.
            n_rem = w_diff[PRIME_W] ? w_trial[PRIME_W-1:0] : w_diff[PRIME_W-1:0];
            n_dvd = {r_dvd[CFG_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_sts.done      = r_done;
    assign o_sts.remainder = r_rem;

endmodule
